// ===== rtl/core/lptm_pkg.sv =====
// Shared constants and types for the page tier migrator.
`timescale 1ns / 1ps
package lptm_pkg;

    localparam int HOT_ENTRIES_DEF = 1024;
    localparam int FAST_PAGES_DEF  = 256;
    localparam int PAGE_BITS_DEF   = 52;

    localparam int CNT_W  = 32;
    localparam int TIME_W = 48;
    localparam int SUM_W  = 48;

    localparam logic [CNT_W-1:0] INTERVAL_RESET = 32'd100;

    // Per-entry metadata of the hotness table
    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] stamp;
    } t_hot_meta;

endpackage

// ===== rtl/core/lfu_page_tier_migrator_unit.sv =====
// Top level: LFU page tier migrator, scan sequencer around the two memories.
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+-------------------------------------
//  input   | i_in_valid   | o_in_ready   | i_command .. i_end_of_sample
//  output  | o_out_valid  | i_out_ready  | o_was_hit .. o_promote_valid
//  config  | i_cfg_valid  | o_cfg_ready  | i_cfg_data (migration interval)
//
// One item at a time; memories are scanned one entry per cycle (pipelined read).
// A load is one fast scan; an access adds a walk of the hot table. A migration
// adds a victim search (each valid fast slot walks the hot table) plus one more
// hot and fast scan.
// Reset is synchronous; no clearing pass (hot validity is the fill count).
// A new item is taken while the previous result still waits in the output register.
`timescale 1ns / 1ps
module lfu_page_tier_migrator_unit import lptm_pkg::*; #(
    parameter int HOT_ENTRIES = HOT_ENTRIES_DEF,
    parameter int FAST_PAGES  = FAST_PAGES_DEF,
    parameter int PAGE_BITS   = PAGE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_command,
    input  logic [PAGE_BITS-1:0] i_page_number,
    input  logic [CNT_W-1:0]     i_access_count,
    input  logic [TIME_W-1:0]    i_time_us,
    input  logic                 i_end_of_sample,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_was_hit,
    output logic [SUM_W-1:0]     o_hits_total,
    output logic [SUM_W-1:0]     o_misses_total,
    output logic                 o_migrated,
    output logic [PAGE_BITS-1:0] o_evicted_page,
    output logic [PAGE_BITS-1:0] o_raised_page,
    output logic                 o_evict_valid,
    output logic                 o_promote_valid,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    localparam int FW  = (FAST_PAGES > 1) ? $clog2(FAST_PAGES) : 1;
    localparam int FCW = $clog2(FAST_PAGES + 1);
    localparam int HW  = $clog2(HOT_ENTRIES);
    localparam int HCW = $clog2(HOT_ENTRIES + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FSCAN  = 4'd1;
    localparam logic [3:0] S_FEND   = 4'd2;
    localparam logic [3:0] S_HSCAN  = 4'd3;
    localparam logic [3:0] S_HWRITE = 4'd4;
    localparam logic [3:0] S_VOUT   = 4'd5;
    localparam logic [3:0] S_VTAG   = 4'd6;
    localparam logic [3:0] S_VIN    = 4'd7;
    localparam logic [3:0] S_VAPPLY = 4'd8;
    localparam logic [3:0] S_PSCAN  = 4'd9;
    localparam logic [3:0] S_PEND   = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0] r_state;

    // latched item
    logic                 r_cmd;
    logic [PAGE_BITS-1:0] r_page;
    logic [CNT_W-1:0]     r_cnt;
    logic [TIME_W-1:0]    r_t;
    logic                 r_eos;

    // architectural state
    logic [CNT_W-1:0]      r_interval;
    logic [FAST_PAGES-1:0] r_fvalid;
    logic [HCW-1:0]        r_occ;
    logic [SUM_W-1:0]      r_hsum;
    logic [SUM_W-1:0]      r_msum;
    logic [TIME_W-1:0]     r_ws;
    logic                  r_started;

    // fast scan engine
    logic                 r_promo;
    logic [PAGE_BITS-1:0] r_key;
    logic [FCW-1:0]       r_fidx;
    logic                 r_fpv;
    logic [FW-1:0]        r_fpidx;
    logic                 r_ffound;
    logic                 r_ffree_v;
    logic [FW-1:0]        r_ffree;

    // hot scan engine
    logic [HCW-1:0]    r_hidx;
    logic              r_hpv;
    logic [HW-1:0]     r_hpidx;
    logic              r_hfound;
    logic [HW-1:0]     r_hslot;
    logic [CNT_W-1:0]  r_hcnt;
    logic              r_old_v;
    logic [TIME_W-1:0] r_oldest;
    logic [HW-1:0]     r_oldslot;

    // victim search
    logic [FCW-1:0]       r_j;
    logic [PAGE_BITS-1:0] r_vtag;
    logic                 r_vm;
    logic [CNT_W-1:0]     r_vmcnt;
    logic                 r_vic_v;
    logic [FW-1:0]        r_vic;
    logic [CNT_W-1:0]     r_least;

    // promotion search
    logic [CNT_W-1:0] r_most;

    // result being built
    logic                 r_hit;
    logic                 r_mig;
    logic [PAGE_BITS-1:0] r_evp;
    logic [PAGE_BITS-1:0] r_prp;
    logic                 r_prv;

    logic r_ovld;

    // memory ports
    logic                 f_we;
    logic [FW-1:0]        f_waddr;
    logic [FW-1:0]        f_raddr;
    logic [PAGE_BITS-1:0] f_rdata;
    logic                 h_we;
    logic [HW-1:0]        h_waddr;
    t_hot_meta            h_wmeta;
    logic [PAGE_BITS-1:0] h_rtag;
    t_hot_meta            h_rmeta;

    logic                 hot_full;
    logic                 f_scan_done;
    logic                 h_scan_done;
    logic                 h_issue;
    logic [SUM_W:0]       sum_add;
    logic [TIME_W-1:0]    elapsed;
    logic                 mig_go;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovld;

    assign hot_full    = (r_occ == HCW'(HOT_ENTRIES));
    assign f_scan_done = (r_fidx == FCW'(FAST_PAGES)) && !r_fpv;
    assign h_issue     = (r_hidx != r_occ) && !(r_state == S_VIN && r_vm);
    assign h_scan_done = !r_hpv && ((r_hidx == r_occ) || (r_state == S_VIN && r_vm));
    assign sum_add     = {1'b0, r_ffound ? r_hsum : r_msum} + (SUM_W + 1)'(r_cnt);
    assign elapsed     = r_t - r_ws;
    assign mig_go      = r_eos && (r_t > r_ws) && (elapsed > TIME_W'(r_interval));

    // fast memory ports
    assign f_raddr = (r_state == S_VOUT) ? r_j[FW-1:0] : r_fidx[FW-1:0];
    assign f_we    = (r_state == S_FEND) && !r_ffound && r_ffree_v && (r_promo || !r_cmd);
    assign f_waddr = r_ffree;

    // hot memory write: bump a known page, else insert at end or over the oldest
    always_comb begin
        h_we          = (r_state == S_HWRITE);
        h_wmeta.stamp = r_t;
        if (r_hfound) begin
            h_waddr       = r_hslot;
            h_wmeta.count = (r_hcnt == '1) ? r_hcnt : r_hcnt + CNT_W'(1);
        end else begin
            h_waddr       = hot_full ? r_oldslot : r_occ[HW-1:0];
            h_wmeta.count = r_cnt;
        end
    end

    lptm_fast_store #(
        .DEPTH (FAST_PAGES),
        .AW    (FW),
        .DW    (PAGE_BITS)
    ) u_fast (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (r_key),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    lptm_hot_store #(
        .DEPTH (HOT_ENTRIES),
        .AW    (HW),
        .DW    (PAGE_BITS)
    ) u_hot (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wtag  (r_page),
        .i_wmeta (h_wmeta),
        .i_raddr (r_hidx[HW-1:0]),
        .o_rtag  (h_rtag),
        .o_rmeta (h_rmeta)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RESET;
        end else if (i_cfg_valid) begin
            r_interval <= i_cfg_data;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fvalid  <= '0;
            r_occ     <= '0;
            r_hsum    <= '0;
            r_msum    <= '0;
            r_ws      <= '0;
            r_started <= 1'b0;
            r_ovld    <= 1'b0;
            r_fpv     <= 1'b0;
            r_hpv     <= 1'b0;
        end else begin
            // result taken; S_DONE handles its own refill
            if (r_ovld && i_out_ready && r_state != S_DONE) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd     <= i_command;
                        r_page    <= i_page_number;
                        r_cnt     <= i_access_count;
                        r_t       <= i_time_us;
                        r_eos     <= i_end_of_sample;
                        r_key     <= i_page_number;
                        r_promo   <= 1'b0;
                        r_hit     <= 1'b0;
                        r_mig     <= 1'b0;
                        r_evp     <= '0;
                        r_vic_v   <= 1'b0;
                        r_prp     <= '0;
                        r_prv     <= 1'b0;
                        r_fidx    <= '0;
                        r_fpv     <= 1'b0;
                        r_ffound  <= 1'b0;
                        r_ffree_v <= 1'b0;
                        r_state   <= S_FSCAN;
                    end
                end

                // walk the fast set: membership and first free slot
                S_FSCAN: begin
                    if (r_fidx != FCW'(FAST_PAGES)) begin
                        r_fpv   <= 1'b1;
                        r_fpidx <= r_fidx[FW-1:0];
                        r_fidx  <= r_fidx + FCW'(1);
                    end else begin
                        r_fpv <= 1'b0;
                    end
                    if (r_fpv) begin
                        if (r_fvalid[r_fpidx]) begin
                            if (f_rdata == r_key) begin
                                r_ffound <= 1'b1;
                            end
                        end else if (!r_ffree_v) begin
                            r_ffree_v <= 1'b1;
                            r_ffree   <= r_fpidx;
                        end
                    end
                    if (f_scan_done) begin
                        r_state <= S_FEND;
                    end
                end

                S_FEND: begin
                    if (f_we) begin
                        r_fvalid[r_ffree] <= 1'b1;
                    end
                    if (r_promo) begin
                        r_ws    <= r_t;
                        r_state <= S_DONE;
                    end else if (!r_cmd) begin
                        r_state <= S_DONE;
                    end else begin
                        r_hit <= r_ffound;
                        if (r_ffound) begin
                            r_hsum <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                        end else begin
                            r_msum <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                        end
                        if (!r_started) begin
                            r_started <= 1'b1;
                            r_ws      <= r_t;
                        end
                        r_hidx   <= '0;
                        r_hpv    <= 1'b0;
                        r_hfound <= 1'b0;
                        r_old_v  <= 1'b0;
                        r_state  <= S_HSCAN;
                    end
                end

                // walk the hot table: lookup and oldest entry
                S_HSCAN: begin
                    r_hpv <= h_issue;
                    if (h_issue) begin
                        r_hpidx <= r_hidx[HW-1:0];
                        r_hidx  <= r_hidx + HCW'(1);
                    end
                    if (r_hpv) begin
                        if (!r_hfound && h_rtag == r_page) begin
                            r_hfound <= 1'b1;
                            r_hslot  <= r_hpidx;
                            r_hcnt   <= h_rmeta.count;
                        end
                        if (!r_old_v || h_rmeta.stamp <= r_oldest) begin
                            r_old_v   <= 1'b1;
                            r_oldest  <= h_rmeta.stamp;
                            r_oldslot <= r_hpidx;
                        end
                    end
                    if (h_scan_done) begin
                        r_state <= S_HWRITE;
                    end
                end

                S_HWRITE: begin
                    if (!r_hfound && !hot_full) begin
                        r_occ <= r_occ + HCW'(1);
                    end
                    if (mig_go) begin
                        r_mig   <= 1'b1;
                        r_j     <= '0;
                        r_state <= S_VOUT;
                    end else begin
                        r_state <= S_DONE;
                    end
                end

                // victim search, outer walk over fast slots
                S_VOUT: begin
                    if (r_j == FCW'(FAST_PAGES)) begin
                        r_state <= S_VAPPLY;
                    end else if (!r_fvalid[r_j[FW-1:0]]) begin
                        r_j <= r_j + FCW'(1);
                    end else begin
                        r_state <= S_VTAG;
                    end
                end

                S_VTAG: begin
                    r_vtag  <= f_rdata;
                    r_hidx  <= '0;
                    r_hpv   <= 1'b0;
                    r_vm    <= 1'b0;
                    r_state <= S_VIN;
                end

                // inner walk: look the fast page up in the hot table
                S_VIN: begin
                    r_hpv <= h_issue;
                    if (h_issue) begin
                        r_hidx <= r_hidx + HCW'(1);
                    end
                    if (r_hpv && !r_vm && h_rtag == r_vtag) begin
                        r_vm    <= 1'b1;
                        r_vmcnt <= h_rmeta.count;
                    end
                    if (h_scan_done) begin
                        if (!r_vm) begin
                            r_vic_v <= 1'b1;
                            r_vic   <= r_j[FW-1:0];
                            r_evp   <= r_vtag;
                            r_state <= S_VAPPLY;
                        end else begin
                            if (!r_vic_v || r_vmcnt < r_least) begin
                                r_vic_v <= 1'b1;
                                r_vic   <= r_j[FW-1:0];
                                r_evp   <= r_vtag;
                                r_least <= r_vmcnt;
                            end
                            r_j     <= r_j + FCW'(1);
                            r_state <= S_VOUT;
                        end
                    end
                end

                S_VAPPLY: begin
                    if (r_vic_v) begin
                        r_fvalid[r_vic] <= 1'b0;
                    end
                    r_hidx  <= '0;
                    r_hpv   <= 1'b0;
                    r_most  <= '0;
                    r_state <= S_PSCAN;
                end

                // hottest entry, strictly greater, first wins
                S_PSCAN: begin
                    r_hpv <= h_issue;
                    if (h_issue) begin
                        r_hidx <= r_hidx + HCW'(1);
                    end
                    if (r_hpv && h_rmeta.count > r_most) begin
                        r_most <= h_rmeta.count;
                        r_prp  <= h_rtag;
                        r_prv  <= 1'b1;
                    end
                    if (h_scan_done) begin
                        r_state <= S_PEND;
                    end
                end

                S_PEND: begin
                    if (r_prv) begin
                        r_key     <= r_prp;
                        r_promo   <= 1'b1;
                        r_fidx    <= '0;
                        r_fpv     <= 1'b0;
                        r_ffound  <= 1'b0;
                        r_ffree_v <= 1'b0;
                        r_state   <= S_FSCAN;
                    end else begin
                        r_ws    <= r_t;
                        r_state <= S_DONE;
                    end
                end

                // hand the result to the output register
                S_DONE: begin
                    if (!r_ovld || i_out_ready) begin
                        r_ovld  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ovld || i_out_ready)) begin
            o_was_hit       <= r_hit;
            o_hits_total    <= r_hsum;
            o_misses_total  <= r_msum;
            o_migrated      <= r_mig;
            o_evicted_page  <= r_evp;
            o_evict_valid   <= r_vic_v;
            o_raised_page   <= r_prp;
            o_promote_valid <= r_prv;
        end
    end

endmodule

// ===== rtl/core/lptm_fast_store.sv =====
// Fast-tier page tag memory, one read and one write port.
`timescale 1ns / 1ps
module lptm_fast_store import lptm_pkg::*; #(
    parameter int DEPTH = FAST_PAGES_DEF,
    parameter int AW    = 8,
    parameter int DW    = PAGE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/core/lptm_hot_store.sv =====
// Hotness table memory: page tags plus count and time stamp per entry.
`timescale 1ns / 1ps
module lptm_hot_store import lptm_pkg::*; #(
    parameter int DEPTH = HOT_ENTRIES_DEF,
    parameter int AW    = 10,
    parameter int DW    = PAGE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wtag,
    input  t_hot_meta     i_wmeta,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rtag,
    output t_hot_meta     o_rmeta
);

    logic [DW-1:0] r_tags [DEPTH];
    t_hot_meta     r_meta [DEPTH];

    // write port, tag and metadata together
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_tags[i_waddr] <= i_wtag;
            r_meta[i_waddr] <= i_wmeta;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        o_rtag  <= r_tags[i_raddr];
        o_rmeta <= r_meta[i_raddr];
    end

endmodule

// ===== tb/sv/lfu_page_tier_migrator_unit_chk.sv =====
// Checker: watches the channels, predicts each result and compares it.
`timescale 1ns / 1ps
module lfu_page_tier_migrator_unit_chk import lptm_pkg::*; #(
    parameter int HOT_ENTRIES = HOT_ENTRIES_DEF,
    parameter int FAST_PAGES  = FAST_PAGES_DEF,
    parameter int PAGE_BITS   = PAGE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_command,
    input  logic [PAGE_BITS-1:0] i_page_number,
    input  logic [CNT_W-1:0]     i_access_count,
    input  logic [TIME_W-1:0]    i_time_us,
    input  logic                 i_end_of_sample,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_was_hit,
    input  logic [SUM_W-1:0]     i_hits_total,
    input  logic [SUM_W-1:0]     i_misses_total,
    input  logic                 i_migrated,
    input  logic [PAGE_BITS-1:0] i_evicted_page,
    input  logic [PAGE_BITS-1:0] i_raised_page,
    input  logic                 i_evict_valid,
    input  logic                 i_promote_valid,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CNT_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic                 was_hit;
        logic [SUM_W-1:0]     hits;
        logic [SUM_W-1:0]     misses;
        logic                 migrated;
        logic [PAGE_BITS-1:0] evicted;
        logic [PAGE_BITS-1:0] promoted;
        logic                 evict_vld;
        logic                 promote_vld;
    } t_tier_result;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Shadow copy of the block state
    logic [CNT_W-1:0]     interval;
    logic [PAGE_BITS-1:0] fast_tag [FAST_PAGES];
    logic                 fast_vld [FAST_PAGES];
    logic [PAGE_BITS-1:0] hot_tag  [HOT_ENTRIES];
    logic [CNT_W-1:0]     hot_cnt  [HOT_ENTRIES];
    logic [TIME_W-1:0]    hot_tm   [HOT_ENTRIES];
    logic                 hot_vld  [HOT_ENTRIES];
    int                   hot_occ;
    logic [SUM_W-1:0]     hit_acc, miss_acc;
    logic [TIME_W-1:0]    win_start;
    logic                 win_open;
    t_tier_result         expected_results [$];

    function automatic int fast_slot(logic [PAGE_BITS-1:0] pg);
        for (int i = 0; i < FAST_PAGES; i++)
            if (fast_vld[i] && fast_tag[i] == pg) return i;
        return -1;
    endfunction

    function automatic int hot_slot(logic [PAGE_BITS-1:0] pg);
        for (int i = 0; i < HOT_ENTRIES; i++)
            if (hot_vld[i] && hot_tag[i] == pg) return i;
        return -1;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [CNT_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + b;
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    task automatic fast_add(logic [PAGE_BITS-1:0] pg);
        if (fast_slot(pg) >= 0) return;
        for (int i = 0; i < FAST_PAGES; i++)
            if (!fast_vld[i]) begin
                fast_vld[i] = 1'b1;
                fast_tag[i] = pg;
                return;
            end
    endtask

    task automatic hot_update(logic [PAGE_BITS-1:0] pg, logic [CNT_W-1:0] cnt,
                              logic [TIME_W-1:0] t);
        int s;
        int old;
        s = hot_slot(pg);
        if (s >= 0) begin
            if (hot_cnt[s] != CNT_MAX) hot_cnt[s]++;
            hot_tm[s] = t;
            return;
        end
        // full table: drop the oldest, ties to the highest slot
        if (hot_occ >= HOT_ENTRIES) begin
            old = -1;
            for (int i = 0; i < HOT_ENTRIES; i++)
                if (hot_vld[i] && (old < 0 || hot_tm[i] <= hot_tm[old])) old = i;
            if (old >= 0) begin
                hot_vld[old] = 1'b0;
                hot_occ--;
            end
        end
        for (int i = 0; i < HOT_ENTRIES; i++)
            if (!hot_vld[i]) begin
                hot_vld[i] = 1'b1;
                hot_tag[i] = pg;
                hot_cnt[i] = cnt;
                hot_tm[i]  = t;
                hot_occ++;
                return;
            end
    endtask

    task automatic predict_tier(output t_tier_result r);
        int victim, best, h;
        logic [CNT_W:0] least;
        logic [CNT_W-1:0] most;
        r = '0;
        if (!i_command) begin
            fast_add(i_page_number);
        end else begin
            if (!win_open) begin
                win_open  = 1'b1;
                win_start = i_time_us;
            end
            if (fast_slot(i_page_number) >= 0) begin
                r.was_hit = 1'b1;
                hit_acc = sat_add(hit_acc, i_access_count);
            end else begin
                miss_acc = sat_add(miss_acc, i_access_count);
            end
            hot_update(i_page_number, i_access_count, i_time_us);
            if (i_end_of_sample && i_time_us > win_start &&
                (i_time_us - win_start) > {16'd0, interval}) begin
                r.migrated = 1'b1;
                victim = -1;
                least  = '1;
                for (int i = 0; i < FAST_PAGES; i++) begin
                    if (!fast_vld[i]) continue;
                    h = hot_slot(fast_tag[i]);
                    if (h < 0) begin
                        victim = i;
                        break;
                    end
                    if ({1'b0, hot_cnt[h]} < least) begin
                        least  = {1'b0, hot_cnt[h]};
                        victim = i;
                    end
                end
                if (victim >= 0) begin
                    r.evicted   = fast_tag[victim];
                    r.evict_vld = 1'b1;
                    fast_vld[victim] = 1'b0;
                end
                best = -1;
                most = '0;
                for (int i = 0; i < HOT_ENTRIES; i++)
                    if (hot_vld[i] && hot_cnt[i] > most) begin
                        most = hot_cnt[i];
                        best = i;
                    end
                if (best >= 0) begin
                    r.promoted    = hot_tag[best];
                    r.promote_vld = 1'b1;
                    fast_add(hot_tag[best]);
                end
                win_start = i_time_us;
            end
        end
        r.hits   = hit_acc;
        r.misses = miss_acc;
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    // Sample all transfers on the rising edge
    always @(posedge i_clk) begin
        t_tier_result r;
        if (!i_rst_n) begin
            interval  = INTERVAL_RESET;
            for (int i = 0; i < FAST_PAGES; i++) fast_vld[i] = 1'b0;
            for (int i = 0; i < HOT_ENTRIES; i++) hot_vld[i] = 1'b0;
            hot_occ   = 0;
            hit_acc   = '0;
            miss_acc  = '0;
            win_start = '0;
            win_open  = 1'b0;
            expected_results.delete();
            o_pending = 0;
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) interval = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                predict_tier(r);
                expected_results.insert(expected_results.size(), r);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result transfer with no expectation", $time);
                    o_fail_count++;
                end else begin
                    r = expected_results.pop_front();
                    check_field("was_hit", 64'(r.was_hit), 64'(i_was_hit));
                    check_field("hits_total", 64'(r.hits), 64'(i_hits_total));
                    check_field("misses_total", 64'(r.misses), 64'(i_misses_total));
                    check_field("migrated", 64'(r.migrated), 64'(i_migrated));
                    check_field("evicted_page", 64'(r.evicted), 64'(i_evicted_page));
                    check_field("raised_page", 64'(r.promoted), 64'(i_raised_page));
                    check_field("evict_valid", 64'(r.evict_vld), 64'(i_evict_valid));
                    check_field("promote_valid", 64'(r.promote_vld), 64'(i_promote_valid));
                end
            end
            o_pending = expected_results.size();
        end
    end

endmodule

// ===== tb/sv/lfu_page_tier_migrator_unit_tb.sv =====
// Testbench top: clock, reset, stimulus and verdict for the page tier migrator.
`timescale 1ns / 1ps
module lfu_page_tier_migrator_unit_tb;
    import lptm_pkg::*;

    localparam int PB = PAGE_BITS_DEF;
    localparam longint CYCLE_LIMIT = 100_000_000;
    localparam bit CMD_LOAD = 1'b0;
    localparam bit CMD_ACCESS = 1'b1;
    localparam logic [PB-1:0] PAGE_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    logic              i_clk, i_rst_n;
    logic              i_in_valid, o_in_ready;
    logic              i_command;
    logic [PB-1:0]     i_page_number;
    logic [CNT_W-1:0]  i_access_count;
    logic [TIME_W-1:0] i_time_us;
    logic              i_end_of_sample;
    logic              o_out_valid, i_out_ready;
    logic              o_was_hit, o_migrated, o_evict_valid, o_promote_valid;
    logic [SUM_W-1:0]  o_hits_total, o_misses_total;
    logic [PB-1:0]     o_evicted_page, o_raised_page;
    logic              i_cfg_valid, o_cfg_ready;
    logic [CNT_W-1:0]  i_cfg_data;
    int                fail_count, pending;
    int                sender_idle, recv_stall;
    longint            cycles = 0;
    logic [TIME_W-1:0] now_us;

    lfu_page_tier_migrator_unit i_dut (.*);

    lfu_page_tier_migrator_unit_chk i_chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_command,
        .i_page_number, .i_access_count, .i_time_us, .i_end_of_sample,
        .i_out_valid(o_out_valid), .i_out_ready, .i_was_hit(o_was_hit),
        .i_hits_total(o_hits_total), .i_misses_total(o_misses_total),
        .i_migrated(o_migrated), .i_evicted_page(o_evicted_page),
        .i_raised_page(o_raised_page), .i_evict_valid(o_evict_valid),
        .i_promote_valid(o_promote_valid), .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL lfu_page_tier_migrator_unit");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_stall);

    // One input transfer; valid stays high if the next call follows at once
    task automatic push_item(bit cmd, logic [PB-1:0] pg, logic [CNT_W-1:0] cnt,
                             logic [TIME_W-1:0] t, bit eos);
        while ($urandom_range(99) < sender_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_page_number   <= pg;
        i_access_count  <= cnt;
        i_time_us       <= t;
        i_end_of_sample <= eos;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_interval(logic [CNT_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random access: small page pool so the hot table stays short
    task automatic random_access();
        logic [PB-1:0] pg;
        logic [CNT_W-1:0] cnt;
        int r;
        r = $urandom_range(99);
        if (r < 3) pg = PB'({$urandom, $urandom});
        else if (r < 5) pg = r[0] ? PAGE_MAX : '0;
        else if (r < 50) pg = PB'($urandom_range(24, 1));
        else pg = PB'($urandom_range(139, 100));
        r = $urandom_range(99);
        if (r < 5) cnt = CNT_MAX;
        else if (r < 10) cnt = '0;
        else if (r < 20) cnt = $urandom;
        else cnt = $urandom_range(50);
        if ($urandom_range(99) < 2) now_us = TIME_W'({$urandom, $urandom});
        else now_us = now_us + $urandom_range(60);
        push_item(CMD_ACCESS, pg, cnt, now_us, $urandom_range(99) < 6);
    endtask

    initial begin
        sender_idle = 0;
        recv_stall = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_command = CMD_LOAD;
        i_page_number = '0;
        i_access_count = '0;
        i_time_us = '0;
        i_end_of_sample = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: zero counts, empty fast set at migration, loads, window edges
        push_item(CMD_ACCESS, 52'd7, '0, 48'd10, 1'b1);
        push_item(CMD_ACCESS, 52'd8, '0, 48'd500, 1'b1);
        push_item(CMD_LOAD, '0, '0, '0, 1'b0);
        push_item(CMD_LOAD, PAGE_MAX, CNT_MAX, '1, 1'b0);
        push_item(CMD_LOAD, '0, '0, '0, 1'b0);
        push_item(CMD_LOAD, 52'd3, '0, 48'd1000, 1'b1);
        push_item(CMD_ACCESS, '0, CNT_MAX, 48'd510, 1'b0);
        push_item(CMD_ACCESS, 52'd3, 32'd5, 48'd520, 1'b0);
        push_item(CMD_ACCESS, 52'd9, 32'd100, 48'd400, 1'b1);
        push_item(CMD_ACCESS, 52'd9, 32'd1, 48'd600, 1'b1);
        push_item(CMD_ACCESS, 52'd9, 32'd1, 48'd601, 1'b1);
        push_item(CMD_ACCESS, PAGE_MAX, CNT_MAX, 48'd700, 1'b1);
        push_item(CMD_ACCESS, 52'd3, 32'd2, 48'd800, 1'b1);
        push_item(CMD_ACCESS, 52'd7, 32'd2, 48'd900, 1'b1);
        now_us = 48'd1000;

        // Random phases over interval settings and idling mixes
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_interval(32'd1);
                1: set_interval(CNT_MAX);
                2: set_interval(32'd100);
                3: set_interval(32'd0 + $urandom_range(400, 2));
                4: set_interval(32'd50);
                default: set_interval($urandom);
            endcase
            case (ph % 4)
                0: begin sender_idle = 0;  recv_stall = 0;  end
                1: begin sender_idle = 54; recv_stall = 0;  end
                2: begin sender_idle = 0;  recv_stall = 54; end
                default: begin sender_idle = 34; recv_stall = 34; end
            endcase
            // loads, in phase two enough to overflow the fast set
            for (int k = 0; k < (ph == 2 ? 260 : 6); k++)
                push_item(CMD_LOAD, PB'($urandom_range(119, 100) + (ph == 2 ? k : 0)),
                          $urandom, TIME_W'({$urandom, $urandom}), 1'($urandom_range(1)));
            for (int k = 0; k < 45; k++) random_access();
        end

        drain();
        repeat (40) @(negedge i_clk);
        if (fail_count == 0)
            $display("PASS lfu_page_tier_migrator_unit");
        else
            $display("FAIL lfu_page_tier_migrator_unit");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/lptm_pkg.sv
rtl/core/lptm_fast_store.sv
rtl/core/lptm_hot_store.sv
rtl/core/lfu_page_tier_migrator_unit.sv
tb/sv/lfu_page_tier_migrator_unit_chk.sv
tb/sv/lfu_page_tier_migrator_unit_tb.sv
